// ===== src/pwg_pkg.sv =====
// Shared types and constants for the PCM widen-and-gain block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package pwg_pkg;

    // Field and register widths fixed by the stream format.
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned SAMPLE_BITS_W = 6;
    localparam int unsigned GAIN_W        = 20;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = GAIN_W;
    localparam int unsigned PROD_W        = SAMPLE_W + GAIN_W;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_BITS = 1'b0,
        REG_GAIN        = 1'b1
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_BITS_W-1:0] SAMPLE_BITS_RESET = 6'd16;
    localparam logic [GAIN_W-1:0]        GAIN_RESET        = 20'h10000;

    // Supported sample widths.
    localparam logic [SAMPLE_BITS_W-1:0] SAMPLE_BITS_8  = 6'd8;
    localparam logic [SAMPLE_BITS_W-1:0] SAMPLE_BITS_16 = 6'd16;
    localparam logic [SAMPLE_BITS_W-1:0] SAMPLE_BITS_24 = 6'd24;

    // Offset that turns unsigned 8-bit PCM into two's complement.
    localparam logic [BYTE_W-1:0] OFFSET_8BIT = 8'h80;

    // Saturation limits for the signed 32-bit result.
    localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

    // Side information that travels with every result beat.
    typedef struct packed {
        logic sample_valid;
        logic format_error;
        logic end_of_stream;
    } item_flags_t;

endpackage

// ===== src/pcm_widen_and_gain_top.sv =====
// PCM widen-and-gain top level: configuration registers, byte assembler and
// gain stage. Depends on pwg_pkg, pwg_assemble and pwg_scale.
// The byte that finishes a beat passes the assembler, product and output registers to m_tvalid.
// Throughput: one input byte per cycle unless m_tready stalls; three register stages, one multiplier.
// Reset (aresetn low, synchronous) empties the pipeline, clears the partial
// sample and sets sample_bits to 16 and gain to unity.
`timescale 1ns / 1ps

module pcm_widen_and_gain_top #(
    parameter int unsigned GAIN_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [pwg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pwg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input byte stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] sample_out
    output logic [1:0]                        m_tuser,   // [0] sample_valid, [1] format_error
    output logic                              m_tlast    // end_of_stream
);
    import pwg_pkg::*;

    logic [SAMPLE_BITS_W-1:0] sample_bits_reg, sample_bits_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic                     clear_acc;

    logic                     a_valid;
    logic                     a_ready;
    logic [SAMPLE_W-1:0]      a_mag;
    logic                     a_neg;
    item_flags_t              a_flags;
    item_flags_t              m_flags;

    // Configuration registers; a sample_bits write restarts sample assembly.
    always_comb begin
        sample_bits_next = sample_bits_reg;
        gain_next        = gain_reg;
        clear_acc        = 1'b0;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_BITS: begin
                    sample_bits_next = cfg_wdata[SAMPLE_BITS_W-1:0];
                    clear_acc        = 1'b1;
                end
                REG_GAIN: begin
                    gain_next = cfg_wdata[GAIN_W-1:0];
                end
                default: begin
                    gain_next = gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_bits_reg <= SAMPLE_BITS_RESET;
            gain_reg        <= GAIN_RESET;
        end else begin
            sample_bits_reg <= sample_bits_next;
            gain_reg        <= gain_next;
        end
    end

    pwg_assemble u_assemble (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_bits (sample_bits_reg),
        .clear_i     (clear_acc),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .out_valid   (a_valid),
        .out_ready   (a_ready),
        .out_mag     (a_mag),
        .out_neg     (a_neg),
        .out_flags   (a_flags)
    );

    pwg_scale #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gain       (gain_reg),
        .in_valid   (a_valid),
        .in_ready   (a_ready),
        .in_mag     (a_mag),
        .in_neg     (a_neg),
        .in_flags   (a_flags),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata),
        .out_flags  (m_flags)
    );

    // Flags of the result beat onto the stream sideband.
    assign m_tuser = {m_flags.format_error, m_flags.sample_valid};
    assign m_tlast = m_flags.end_of_stream;

endmodule

// ===== src/pwg_assemble.sv =====
// Byte assembler: gathers little-endian bytes into one sample, widens it to
// a left-justified 32-bit word and splits it into sign and magnitude.
// Depends on pwg_pkg.
`timescale 1ns / 1ps

module pwg_assemble (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [pwg_pkg::SAMPLE_BITS_W-1:0]  sample_bits,
    input  logic                               clear_i,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pwg_pkg::BYTE_W-1:0]         in_byte,
    input  logic                               in_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pwg_pkg::SAMPLE_W-1:0]       out_mag,
    output logic                               out_neg,
    output pwg_pkg::item_flags_t               out_flags
);
    import pwg_pkg::*;

    logic [1:0]          cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   byte0_reg, byte1_reg;
    logic                vld_reg, vld_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic                neg_reg, neg_next;
    item_flags_t         flags_reg, flags_next;

    logic [1:0]          nbytes;
    logic [2:0]          cnt_plus;
    logic                complete;
    logic                fmt_err;
    logic                produce;
    logic                accept;
    logic [SAMPLE_W-1:0] widened;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Bytes per sample for the configured width; zero means unsupported.
    always_comb begin
        case (sample_bits)
            SAMPLE_BITS_8:  nbytes = 2'd1;
            SAMPLE_BITS_16: nbytes = 2'd2;
            SAMPLE_BITS_24: nbytes = 2'd3;
            default:        nbytes = 2'd0;
        endcase
    end

    assign fmt_err  = (nbytes == 2'd0);
    assign cnt_plus = {1'b0, cnt_reg} + 3'd1;
    assign complete = !fmt_err && (cnt_plus >= {1'b0, nbytes});
    assign produce  = fmt_err || complete || in_last;

    // Left-justify the finished sample; 8-bit data is offset to signed.
    always_comb begin
        case (nbytes)
            2'd1:    widened = {in_byte ^ OFFSET_8BIT, 24'd0};
            2'd2:    widened = {in_byte, byte0_reg, 16'd0};
            2'd3:    widened = {in_byte, byte1_reg, byte0_reg, 8'd0};
            default: widened = '0;
        endcase
    end

    // Result beat toward the gain stage.
    always_comb begin
        vld_next   = vld_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        flags_next = flags_reg;
        if (out_ready) begin
            vld_next = 1'b0;
        end
        if (accept && produce) begin
            vld_next                 = 1'b1;
            flags_next.sample_valid  = complete;
            flags_next.format_error  = fmt_err;
            flags_next.end_of_stream = in_last;
            if (complete) begin
                neg_next = widened[SAMPLE_W-1];
                mag_next = widened[SAMPLE_W-1] ? (~widened + 32'd1) : widened;
            end else begin
                neg_next = 1'b0;
                mag_next = '0;
            end
        end
    end

    // Byte count; a width change or any finished beat restarts the sample.
    always_comb begin
        cnt_next = cnt_reg;
        if (clear_i) begin
            cnt_next = 2'd0;
        end else if (accept) begin
            if (produce) begin
                cnt_next = 2'd0;
            end else begin
                cnt_next = cnt_plus[1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    // Partial bytes are held by position; the count says which are live.
    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        flags_reg <= flags_next;
        if (accept && !produce) begin
            if (cnt_reg == 2'd0) begin
                byte0_reg <= in_byte;
            end else begin
                byte1_reg <= in_byte;
            end
        end
    end

    assign out_valid = vld_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_flags = flags_reg;

endmodule

// ===== src/pwg_scale.sv =====
// Gain stage: multiplies the sample magnitude by the unsigned fixed-point
// gain, then truncates, saturates and restores the sign. Depends on pwg_pkg.
`timescale 1ns / 1ps

module pwg_scale #(
    parameter int unsigned GAIN_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pwg_pkg::GAIN_W-1:0]    gain,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pwg_pkg::SAMPLE_W-1:0]  in_mag,
    input  logic                          in_neg,
    input  pwg_pkg::item_flags_t          in_flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwg_pkg::SAMPLE_W-1:0]  out_sample,
    output pwg_pkg::item_flags_t          out_flags
);
    import pwg_pkg::*;

    // Product stage.
    logic                p_vld_reg, p_vld_next;
    logic [PROD_W-1:0]   prod_reg;
    logic                p_neg_reg;
    item_flags_t         p_flags_reg;

    // Output stage.
    logic                o_vld_reg, o_vld_next;
    logic [SAMPLE_W-1:0] o_sample_reg, o_sample_next;
    item_flags_t         o_flags_reg;

    logic                o_rdy;
    logic                p_rdy;
    logic [PROD_W-1:0]   q;
    logic                over;

    assign o_rdy    = !o_vld_reg || out_ready;
    assign p_rdy    = !p_vld_reg || o_rdy;
    assign in_ready = p_rdy;

    assign p_vld_next = p_rdy ? in_valid : p_vld_reg;
    assign o_vld_next = o_rdy ? p_vld_reg : o_vld_reg;

    // Truncate the fraction, then clamp to the signed 32-bit range.
    assign q    = prod_reg >> GAIN_FRAC_BITS;
    assign over = |q[PROD_W-1:SAMPLE_W-1];

    always_comb begin
        if (p_neg_reg) begin
            o_sample_next = over ? SAT_NEG : (~q[SAMPLE_W-1:0] + 32'd1);
        end else begin
            o_sample_next = over ? SAT_POS : q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= p_vld_next;
            o_vld_reg <= o_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_rdy) begin
            prod_reg    <= PROD_W'(in_mag) * PROD_W'(gain);
            p_neg_reg   <= in_neg;
            p_flags_reg <= in_flags;
        end
        if (o_rdy) begin
            o_sample_reg <= o_sample_next;
            o_flags_reg  <= p_flags_reg;
        end
    end

    assign out_valid  = o_vld_reg;
    assign out_sample = o_sample_reg;
    assign out_flags  = o_flags_reg;

endmodule
